FILE: design/fpt_pkg.sv
// Shared constants and opcode type for the page frame table.
// No dependencies; imported by the frame table and its checker.
package fpt_pkg;

    localparam int NUM_FRAMES_DEF     = 16;
    localparam int LOCATION_WIDTH_DEF = 10;
    localparam int COUNT_WIDTH_DEF    = 16;

    localparam int OPCODE_W = 3;
    localparam int FRAME_W  = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_FIND_FREE = 3'd0,
        OP_SET       = 3'd1,
        OP_FREE      = 3'd2,
        OP_GET       = 3'd3,
        OP_TOUCH     = 3'd4,
        OP_VICTIM    = 3'd5
    } opcode_t;

endpackage

FILE: design/frame_table_with_use_count_victim.sv
// Page frame table: used flags, base locations and saturating use counts.
// Depends on fpt_pkg.
//
// One request is taken at a time and always answers with one result beat.
// SET, FREE and the unused opcodes go straight to the result stage; GET
// of a used frame and TOUCH of a valid index first do one registered
// memory read, and TOUCH then writes the increment. FIND_FREE walks the
// used flags one frame a cycle; VICTIM reads every use count through the
// single count memory port and runs it through one shared comparator.
// in_ready is high only while the sequencer is idle; a result waiting in
// the output register does not block the next request until that request
// wants to deliver its own result. No clearing pass after reset: counts
// read as zero until written.
module frame_table_with_use_count_victim #(
    parameter int NUM_FRAMES     = fpt_pkg::NUM_FRAMES_DEF,
    parameter int LOCATION_WIDTH = fpt_pkg::LOCATION_WIDTH_DEF,
    parameter int COUNT_WIDTH    = fpt_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [fpt_pkg::OPCODE_W-1:0] opcode,
    input  logic [fpt_pkg::FRAME_W-1:0]  frame_index,
    input  logic [LOCATION_WIDTH-1:0]    base_location,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         found,
    output logic [fpt_pkg::FRAME_W-1:0]  result_frame,
    output logic [LOCATION_WIDTH-1:0]    result_location
);
    import fpt_pkg::*;

    localparam int IDX_W  = $clog2(NUM_FRAMES);
    localparam int SCAN_W = $clog2(NUM_FRAMES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_VIC,
        S_TRD,
        S_TWR,
        S_GRD,
        S_GWT,
        S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [SCAN_W-1:0]         scan_reg, scan_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      hit_reg, hit_next;
    logic [COUNT_WIDTH-1:0]    best_reg, best_next;
    logic [IDX_W-1:0]          pick_reg, pick_next;
    logic [NUM_FRAMES-1:0]     in_use_reg, in_use_next;
    logic [NUM_FRAMES-1:0]     cnt_vld_reg, cnt_vld_next;
    logic                      res_found_reg, res_found_next;
    logic [FRAME_W-1:0]        res_frame_reg, res_frame_next;
    logic [LOCATION_WIDTH-1:0] res_loc_reg, res_loc_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      found_reg, found_next;
    logic [FRAME_W-1:0]        frame_reg, frame_next;
    logic [LOCATION_WIDTH-1:0] loc_reg, loc_next;

    // memories, registered read
    logic [COUNT_WIDTH-1:0]    count_mem [NUM_FRAMES];
    logic [LOCATION_WIDTH-1:0] base_mem [NUM_FRAMES];
    logic [COUNT_WIDTH-1:0]    cnt_rd_reg;
    logic                      cnt_vld_rd_reg;
    logic [LOCATION_WIDTH-1:0] base_rd_reg;

    logic                      in_fire;
    logic [IDX_W-1:0]          in_idx;
    logic                      idx_ok;
    logic [IDX_W-1:0]          rd_addr;
    logic                      cnt_we;
    logic [COUNT_WIDTH-1:0]    cnt_wdata;
    logic                      base_we;
    logic [COUNT_WIDTH-1:0]    cnt_eff;
    logic [COUNT_WIDTH:0]      alu_sum;
    logic                      alu_lt;
    logic                      upd_hit;
    logic [COUNT_WIDTH-1:0]    upd_best;
    logic [IDX_W-1:0]          upd_pick;
    logic [IDX_W-1:0]          scan_idx;
    logic [IDX_W-1:0]          prev_idx;

    assign in_ready        = (state_reg == S_IDLE);
    assign in_fire         = in_valid && in_ready;
    assign in_idx          = IDX_W'(frame_index);
    assign idx_ok          = (32'(frame_index) < 32'(NUM_FRAMES));
    assign scan_idx        = scan_reg[IDX_W-1:0];
    assign prev_idx        = IDX_W'(scan_reg - SCAN_W'(1));
    assign rd_addr         = (state_reg == S_VIC) ? scan_idx : idx_reg;

    assign out_valid       = out_valid_reg;
    assign found           = found_reg;
    assign result_frame    = frame_reg;
    assign result_location = loc_reg;

    // shared count unit: saturating increment for touch, less-than for victim
    assign cnt_eff = cnt_vld_rd_reg ? cnt_rd_reg : '0;
    assign alu_sum = {1'b0, cnt_eff} + {{COUNT_WIDTH{1'b0}}, 1'b1};
    assign alu_lt  = (cnt_eff < best_reg);

    always_comb
    begin
        upd_hit  = hit_reg;
        upd_best = best_reg;
        upd_pick = pick_reg;
        if ((scan_reg != '0) && (cnt_eff != '0) && (!hit_reg || alu_lt))
        begin
            upd_hit  = 1'b1;
            upd_best = cnt_eff;
            upd_pick = prev_idx;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        best_next      = best_reg;
        pick_next      = pick_reg;
        in_use_next    = in_use_reg;
        cnt_vld_next   = cnt_vld_reg;
        res_found_next = res_found_reg;
        res_frame_next = res_frame_reg;
        res_loc_next   = res_loc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        found_next     = found_reg;
        frame_next     = frame_reg;
        loc_next       = loc_reg;
        cnt_we         = 1'b0;
        cnt_wdata      = alu_sum[COUNT_WIDTH-1:0];
        base_we        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    idx_next       = in_idx;
                    scan_next      = '0;
                    hit_next       = 1'b0;
                    best_next      = '0;
                    pick_next      = '0;
                    res_found_next = 1'b0;
                    res_frame_next = '0;
                    res_loc_next   = '0;
                    state_next     = S_DONE;
                    case (opcode_t'(opcode))
                        OP_FIND_FREE: state_next = S_FREE;
                        OP_SET:
                        begin
                            res_found_next = idx_ok;
                            if (idx_ok)
                            begin
                                base_we             = 1'b1;
                                in_use_next[in_idx] = 1'b1;
                            end
                        end
                        OP_FREE:
                        begin
                            res_found_next = idx_ok;
                            if (idx_ok)
                                in_use_next[in_idx] = 1'b0;
                        end
                        OP_GET:
                        begin
                            if (idx_ok && in_use_reg[in_idx])
                                state_next = S_GRD;
                        end
                        OP_TOUCH:
                        begin
                            if (idx_ok)
                                state_next = S_TRD;
                        end
                        OP_VICTIM: state_next = S_VIC;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_FREE:
            begin
                if (!in_use_reg[scan_idx])
                begin
                    res_found_next = 1'b1;
                    res_frame_next = FRAME_W'(scan_idx);
                    state_next     = S_DONE;
                end
                else if (scan_reg == SCAN_W'(NUM_FRAMES - 1))
                    state_next = S_DONE;
                else
                    scan_next = scan_reg + SCAN_W'(1);
            end
            S_VIC:
            begin
                // data for frame scan-1 arrives while frame scan is read
                hit_next  = upd_hit;
                best_next = upd_best;
                pick_next = upd_pick;
                if (scan_reg == SCAN_W'(NUM_FRAMES))
                begin
                    res_found_next = upd_hit;
                    res_frame_next = upd_hit ? FRAME_W'(upd_pick) : '0;
                    state_next     = S_DONE;
                end
                else
                    scan_next = scan_reg + SCAN_W'(1);
            end
            S_TRD: state_next = S_TWR;
            S_TWR:
            begin
                if (!alu_sum[COUNT_WIDTH])
                begin
                    cnt_we                = 1'b1;
                    cnt_vld_next[idx_reg] = 1'b1;
                end
                res_found_next = 1'b1;
                state_next     = S_DONE;
            end
            S_GRD: state_next = S_GWT;
            S_GWT:
            begin
                res_found_next = 1'b1;
                res_loc_next   = base_rd_reg;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    found_next     = res_found_reg;
                    frame_next     = res_frame_reg;
                    loc_next       = res_loc_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            best_reg      <= '0;
            pick_reg      <= '0;
            in_use_reg    <= '0;
            cnt_vld_reg   <= '0;
            res_found_reg <= 1'b0;
            res_frame_reg <= '0;
            res_loc_reg   <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            frame_reg     <= '0;
            loc_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            idx_reg       <= idx_next;
            hit_reg       <= hit_next;
            best_reg      <= best_next;
            pick_reg      <= pick_next;
            in_use_reg    <= in_use_next;
            cnt_vld_reg   <= cnt_vld_next;
            res_found_reg <= res_found_next;
            res_frame_reg <= res_frame_next;
            res_loc_reg   <= res_loc_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            frame_reg     <= frame_next;
            loc_reg       <= loc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            count_mem[idx_reg] <= cnt_wdata;
        cnt_rd_reg     <= count_mem[rd_addr];
        cnt_vld_rd_reg <= cnt_vld_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (base_we)
            base_mem[in_idx] <= base_location;
        base_rd_reg <= base_mem[idx_reg];
    end

endmodule

FILE: design/fpt_checker.sv
// Port-level checks for the page frame table, bound to the top level.
// Depends on fpt_pkg.
module fpt_checker #(
    parameter int LOCATION_WIDTH = fpt_pkg::LOCATION_WIDTH_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         found,
    input logic [fpt_pkg::FRAME_W-1:0]  result_frame,
    input logic [LOCATION_WIDTH-1:0]    result_location
);
    import fpt_pkg::*;

    // one request at a time: an accepted beat closes the input side
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after an accepted beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found)
            && $stable(result_frame) && $stable(result_location))
        else $error("stalled result beat changed");

    a_loc_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_location != '0) |-> found)
        else $error("location returned without found");

    a_frame_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_frame != '0) |-> found)
        else $error("frame returned without found");

endmodule

bind frame_table_with_use_count_victim fpt_checker #(
    .LOCATION_WIDTH(LOCATION_WIDTH)
) u_fpt_checker (.*);
